@@ hw/rtl/pftd_pkg.sv @@
// shared types, constants and character tables of the packed five-bit text decoder
// no dependencies
package pftd_pkg;

  localparam int BYTE_W          = 8;
  localparam int CODE_W          = 5;
  localparam int CHUNK_W         = 40;
  localparam int CODES_PER_CHUNK = 8;
  localparam int BUF_BYTES       = 4;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CODE_W-1:0] CODE_STOP    = 5'h00;
  localparam logic [CODE_W-1:0] CODE_CAPITAL = 5'h1e;
  localparam logic [CODE_W-1:0] CODE_SYMBOL  = 5'h1f;

  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_AT     = 8'h40;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic               last;
  } job_t;

  function automatic logic [BYTE_W-1:0] lower_char(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] ch;
    if (code >= 5'd2 && code <= 5'd27) begin
      ch = 8'h5f + {3'b000, code};
    end else if (code == 5'd28) begin
      ch = CHAR_SPACE;
    end else begin
      ch = 8'h2e;
    end
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] symbol_char(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] ch;
    unique case (code)
      5'd0, 5'd30: ch = 8'h5b;
      5'd1, 5'd31: ch = 8'h5d;
      5'd2:        ch = 8'h0a;
      5'd3:        ch = 8'h21;
      5'd4:        ch = 8'h22;
      5'd5:        ch = 8'h23;
      5'd6:        ch = 8'h24;
      5'd7:        ch = 8'h25;
      5'd8:        ch = 8'h26;
      5'd9:        ch = 8'h27;
      5'd10:       ch = 8'h28;
      5'd11:       ch = 8'h29;
      5'd12:       ch = 8'h2c;
      5'd13:       ch = 8'h2d;
      5'd14:       ch = 8'h2f;
      5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd23, 5'd24:
                   ch = 8'h21 + {3'b000, code};
      5'd25:       ch = 8'h3a;
      5'd26:       ch = 8'h3b;
      5'd27:       ch = 8'h3f;
      5'd28:       ch = 8'h3c;
      5'd29:       ch = 8'h3e;
      default:     ch = 8'h5b;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] map_code(input logic [CODE_W-1:0] code,
                                                 input logic              capital,
                                                 input logic              symbol);
    logic [BYTE_W-1:0] ch;
    ch = lower_char(code);
    if (symbol) begin
      ch = symbol_char(code);
    end else if (capital) begin
      ch = (ch == CHAR_SPACE) ? CHAR_AT : ch - CASE_OFFSET;
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/pftd_front.sv @@
// front part: byte collection into 40-bit chunks, jobs pushed to the queue
// depends on pftd_pkg
module pftd_front import pftd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] encoded_byte,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_job
);

  logic [BUF_BYTES*BYTE_W-1:0] chunk_bytes;
  logic [2:0]                  byte_count;
  logic                        accept;
  logic                        zero_byte;
  logic [CHUNK_W-1:0]          padded;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign zero_byte = (encoded_byte == '0);
  assign q_push    = accept && (zero_byte || byte_count == 3'(BUF_BYTES));

  always_comb begin
    unique case (byte_count)
      3'd1:    padded = {chunk_bytes[7:0], 32'h0};
      3'd2:    padded = {chunk_bytes[15:0], 24'h0};
      3'd3:    padded = {chunk_bytes[23:0], 16'h0};
      3'd4:    padded = {chunk_bytes, 8'h0};
      default: padded = '0;
    endcase
  end

  always_comb begin
    q_job.chunk = zero_byte ? padded : {chunk_bytes, encoded_byte};
    q_job.last  = zero_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= '0;
      byte_count  <= '0;
    end else if (accept) begin
      if (q_push) begin
        chunk_bytes <= '0;
        byte_count  <= '0;
      end else begin
        chunk_bytes <= {chunk_bytes[23:0], encoded_byte};
        byte_count  <= byte_count + 3'd1;
      end
    end
  end

endmodule

@@ hw/rtl/pftd_queue.sv @@
// small job queue between front and back parts
// depends on pftd_pkg
module pftd_queue import pftd_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/pftd_back.sv @@
// back part: one code per cycle decode while the output is not stalled, registered result output
// depends on pftd_pkg
module pftd_back import pftd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] char_code,
  output logic              char_valid,
  output logic              string_end
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_MARK   = 3'b100
  } back_state_t;

  back_state_t        state, state_next;
  logic [CHUNK_W-1:0] chunk, chunk_next;
  logic [2:0]         idx, idx_next;
  logic               last, last_next;
  logic               upper, upper_next;
  logic               symbol, symbol_next;
  logic               stopped, stopped_next;
  logic               out_free;
  logic               emit;
  logic [BYTE_W-1:0]  emit_code;
  logic               emit_char;
  logic               emit_end;
  logic [CODE_W-1:0]  code;
  back_state_t        done_state;

  assign out_free   = !out_valid || !out_stall;
  assign code       = chunk[CHUNK_W-1 -: CODE_W];
  assign done_state = last ? ST_MARK : ST_IDLE;

  always_comb begin
    state_next   = state;
    chunk_next   = chunk;
    idx_next     = idx;
    last_next    = last;
    upper_next   = upper;
    symbol_next  = symbol;
    stopped_next = stopped;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_code    = '0;
    emit_char    = 1'b0;
    emit_end     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          chunk_next = q_job.chunk;
          last_next  = q_job.last;
          idx_next   = '0;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (out_free) begin
          chunk_next = chunk << CODE_W;
          idx_next   = idx + 3'd1;
          if (stopped) begin
            state_next = done_state;
          end else begin
            priority if (code == CODE_STOP) begin
              stopped_next = 1'b1;
              state_next   = done_state;
            end else if (code == CODE_CAPITAL) begin
              upper_next = 1'b1;
            end else if (code == CODE_SYMBOL) begin
              symbol_next = 1'b1;
            end else begin
              emit        = 1'b1;
              emit_char   = 1'b1;
              emit_code   = map_code(code, upper, symbol);
              upper_next  = 1'b0;
              symbol_next = 1'b0;
            end
            if (idx == 3'(CODES_PER_CHUNK - 1)) begin
              state_next = done_state;
            end
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_end     = 1'b1;
          upper_next   = 1'b0;
          symbol_next  = 1'b0;
          stopped_next = 1'b0;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      upper     <= 1'b0;
      symbol    <= 1'b0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      upper   <= upper_next;
      symbol  <= symbol_next;
      stopped <= stopped_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    chunk <= chunk_next;
    idx   <= idx_next;
    last  <= last_next;
    if (out_free) begin
      char_code  <= emit_code;
      char_valid <= emit_char;
      string_end <= emit_end;
    end
  end

endmodule

@@ hw/rtl/packed_five_bit_text_decoder_core.sv @@
// path: after a fifth or zero byte a result passes queue, chunk load and output register, and
// a decode step more per prefix code before it; with no bytes held, an end marker passes a
// stop-code decode step too, then the mark state. flow: one byte per cycle while the queue
// is not full; back part: load per chunk, decode per code to a stop code, mark per end marker
// reset: synchronous rst clears byte buffer, queue, back state, pending flags and output valid
// depends on pftd_pkg, pftd_front, pftd_queue, pftd_back
module packed_five_bit_text_decoder_core import pftd_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] encoded_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] char_code,
  output logic              char_valid,
  output logic              string_end
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t pop_job;

  pftd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .encoded_byte (encoded_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  pftd_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (pop_job)
  );

  pftd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .char_valid (char_valid),
    .string_end (string_end)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job pushed into a full queue");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid != string_end))
    else $error("result is neither a character nor an end marker");

  a_marker_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> char_code == '0)
    else $error("end marker carries a nonzero code");

  a_pop_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

@@ verif/tb.sv @@
// testbench for packed_five_bit_text_decoder_core: byte-stream stimulus and per-result checks
// against a predictor of the five-bit text decoding, with random idling on both channels
// depends on pftd_pkg and the decoder rtl
module tb import pftd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              valid;
    logic              str_end;
  } char_result_t;

  localparam int IDLE_PCT       = 35;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [CODE_W-1:0] LOWER_PERIOD = 5'd1;
  localparam logic [CODE_W-1:0] LOWER_A      = 5'd2;
  localparam logic [CODE_W-1:0] LOWER_Z      = 5'd27;
  localparam logic [CODE_W-1:0] LOWER_SPACE  = 5'd28;
  localparam logic [CODE_W-1:0] LOWER_LAST   = 5'd29;
  localparam logic [CODE_W-1:0] SYM_HASH     = 5'd5;
  localparam logic [CODE_W-1:0] SYM_QUOTE    = 5'd4;
  localparam logic [CODE_W-1:0] SYM_BANG     = 5'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] encoded_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] char_code;
  logic              char_valid;
  logic              string_end;

  string lower_chars  = "..abcdefghijklmnopqrstuvwxyz .";
  string symbol_chars = "[]\n!\"#$%&'(),-/0123456789:;?<>";

  logic [BUF_BYTES*BYTE_W-1:0] held_bytes = '0;
  logic [2:0]                  held_count = '0;
  logic                        cap_pend = 1'b0;
  logic                        sym_pend = 1'b0;
  logic                        stopped = 1'b0;

  char_result_t expected_chars[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  logic         no_idle = 1'b0;

  packed_five_bit_text_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .encoded_byte (encoded_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .char_valid   (char_valid),
    .string_end   (string_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_expected(input char_result_t res);
    expected_chars = {expected_chars, res};
  endfunction

  function automatic logic [BYTE_W-1:0] char_for(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] ch;
    if (sym_pend) begin
      ch = symbol_chars.getc(int'(code) % 30);
    end else begin
      ch = lower_chars.getc(int'(code) % 30);
      if (cap_pend) begin
        ch = (ch == CHAR_SPACE) ? CHAR_AT : ch - CASE_OFFSET;
      end
    end
    return ch;
  endfunction

  function automatic void decode_chunk(input logic [CHUNK_W-1:0] chunk);
    logic [CODE_W-1:0] code;
    for (int j = 0; j < CODES_PER_CHUNK; j++) begin
      if (stopped) break;
      code = CODE_W'(chunk >> (CHUNK_W - CODE_W - CODE_W * j));
      if (code == CODE_STOP) begin
        stopped = 1'b1;
      end else if (code == CODE_CAPITAL) begin
        cap_pend = 1'b1;
      end else if (code == CODE_SYMBOL) begin
        sym_pend = 1'b1;
      end else begin
        add_expected(char_result_t'{char_for(code), 1'b1, 1'b0});
        cap_pend = 1'b0;
        sym_pend = 1'b0;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [CHUNK_W-1:0] padded;
    if (b != '0) begin
      if (held_count < BUF_BYTES) begin
        held_bytes = {held_bytes[(BUF_BYTES-1)*BYTE_W-1:0], b};
        held_count = held_count + 3'd1;
      end else begin
        decode_chunk({held_bytes, b});
        held_bytes = '0;
        held_count = '0;
      end
    end else begin
      if (held_count != 0) begin
        padded = {{BYTE_W{1'b0}}, held_bytes};
        padded = padded << (BYTE_W * (5 - int'(held_count)));
        decode_chunk(padded);
      end
      add_expected(char_result_t'{8'h00, 1'b0, 1'b1});
      held_bytes = '0;
      held_count = '0;
      cap_pend   = 1'b0;
      sym_pend   = 1'b0;
      stopped    = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    encoded_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
    items_sent++;
  endtask

  task automatic send_chunk_bytes(input logic [CHUNK_W-1:0] chunk, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(chunk[CHUNK_W-1-BYTE_W*i -: BYTE_W]);
    end
  endtask

  function automatic logic [CHUNK_W-1:0] random_chunk();
    logic [CHUNK_W-1:0] chunk;
    int                 pick;
    chunk = '0;
    for (int j = 0; j < CODES_PER_CHUNK; j++) begin
      pick = $urandom_range(0, 99);
      chunk = chunk << CODE_W;
      if (pick < 4) begin
        chunk[CODE_W-1:0] = CODE_STOP;
      end else if (pick < 16) begin
        chunk[CODE_W-1:0] = CODE_CAPITAL;
      end else if (pick < 28) begin
        chunk[CODE_W-1:0] = CODE_SYMBOL;
      end else begin
        chunk[CODE_W-1:0] = CODE_W'($urandom_range(1, 29));
      end
    end
    return chunk;
  endfunction

  task automatic send_random_string();
    if ($urandom_range(0, 99) < 80) begin
      repeat ($urandom_range(0, 3)) send_chunk_bytes(random_chunk(), 5);
      send_chunk_bytes(random_chunk(), $urandom_range(0, 4));
    end else begin
      repeat ($urandom_range(0, 12)) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
    send_byte('0);
  endtask

  // empty string gives the end marker alone
  task automatic test_empty_string();
    send_byte('0);
  endtask

  task automatic test_capitals();
    send_chunk_bytes({LOWER_A, CODE_CAPITAL, LOWER_A, CODE_CAPITAL, LOWER_SPACE,
                      CODE_CAPITAL, LOWER_PERIOD, LOWER_LAST}, 5);
    send_byte('0);
  endtask

  // both prefixes, prefixes held across chunks, stop code with bytes after it
  task automatic test_prefixes_and_stop();
    send_chunk_bytes({CODE_SYMBOL, CODE_CAPITAL, SYM_HASH, LOWER_Z, CODE_SYMBOL,
                      CODE_SYMBOL, CODE_CAPITAL, CODE_SYMBOL}, 5);
    send_chunk_bytes({SYM_QUOTE, CODE_STOP, SYM_BANG, SYM_BANG, SYM_BANG,
                      SYM_BANG, SYM_BANG, SYM_BANG}, 5);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte('0);
  endtask

  task automatic test_partial_chunk();
    repeat (BUF_BYTES) send_byte(8'hff);
    send_byte('0);
  endtask

  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_string();
  endtask

  task automatic test_back_to_back(input int count);
    int stop_at;
    stop_at = items_sent + count;
    no_idle = 1'b1;
    while (items_sent < stop_at) send_random_string();
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    char_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected item char_code=%h char_valid=%b string_end=%b",
                 $time, char_code, char_valid, string_end);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.ch) begin
          $display("%0t: char_code expected %h actual %h", $time, want.ch, char_code);
          mismatch_count++;
        end
        if (char_valid !== want.valid) begin
          $display("%0t: char_valid expected %b actual %b", $time, want.valid, char_valid);
          mismatch_count++;
        end
        if (string_end !== want.str_end) begin
          $display("%0t: string_end expected %b actual %b", $time, want.str_end, string_end);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_string();
    test_capitals();
    test_prefixes_and_stop();
    test_partial_chunk();
    test_random_strings(330);
    test_back_to_back(110);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
